/* rtl/core/ttb_pkg.sv */
// Shared widths, types and constants for the triangle tangent/bitangent core.
package ttb_pkg;

  localparam int POS_W   = 24;
  localparam int TEX_W   = 16;
  localparam int OUT_W   = 32;
  localparam int DPOS_W  = POS_W + 1;
  localparam int DTEX_W  = TEX_W + 1;
  localparam int PROD_W  = DPOS_W + DTEX_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DET_W   = 2 * DTEX_W + 2;
  localparam int QUOT_SHIFT = 18;
  // Quotient of the doubled dividend; its last bit drives rounding.
  localparam int DIV_STEPS  = OUT_W + 2;
  localparam int DIV_CNT_W  = 6;
  localparam int NUM_COMP   = 6;

  typedef struct packed {
    logic valid;
    logic first;
  } ttb_mac_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } ttb_div_stat_t;

endpackage

/* rtl/core/ttb_if.sv */
// Valid/ready channel interfaces for vertex words and result words.
interface ttb_vtx_if;
  logic valid;
  logic ready;
  logic signed [ttb_pkg::POS_W-1:0] pos_x;
  logic signed [ttb_pkg::POS_W-1:0] pos_y;
  logic signed [ttb_pkg::POS_W-1:0] pos_z;
  logic signed [ttb_pkg::TEX_W-1:0] tex_u;
  logic signed [ttb_pkg::TEX_W-1:0] tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if;
  logic valid;
  logic ready;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_x;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_y;
  logic signed [ttb_pkg::OUT_W-1:0] tangent_z;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_x;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_y;
  logic signed [ttb_pkg::OUT_W-1:0] bitangent_z;
  logic degenerate;
  logic saturated;
  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, degenerate, saturated, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                bitangent_z, degenerate, saturated, output ready);
endinterface

/* rtl/core/ttb_mac.sv */
// Shared multiplier with a product register and a multiply-subtract accumulator.
module ttb_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ttb_pkg::ttb_mac_ctl_t                ctl,
  input  logic signed [ttb_pkg::DPOS_W-1:0]    a,
  input  logic signed [ttb_pkg::DTEX_W-1:0]    b,
  output logic signed [ttb_pkg::ACC_W-1:0]     acc
);

  logic signed [ttb_pkg::PROD_W-1:0] prod;
  logic                              prod_valid;
  logic                              prod_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
    end
    prod_first <= ctl.first;
    prod       <= a * b;
  end

  // The first term of a pair loads the accumulator; the second is subtracted.
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      if (prod_first) begin
        acc <= ttb_pkg::ACC_W'(prod);
      end else begin
        acc <= acc - ttb_pkg::ACC_W'(prod);
      end
    end
  end

endmodule

/* rtl/core/ttb_div.sv */
// Bit-serial restoring divider with round-to-nearest and saturation to Q14.18.
module ttb_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ttb_pkg::ACC_W-1:0]    num,
  input  logic signed [ttb_pkg::DET_W-1:0]    den,
  output ttb_pkg::ttb_div_stat_t              stat,
  output logic signed [ttb_pkg::OUT_W-1:0]    quot
);

  localparam int NHI_W = ttb_pkg::ACC_W - (ttb_pkg::DIV_STEPS - 1 - ttb_pkg::QUOT_SHIFT);
  localparam int NLO_W = ttb_pkg::ACC_W - NHI_W;
  localparam int REM_W = ttb_pkg::DET_W + 1;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_t;

  dv_state_t state;
  logic [ttb_pkg::DIV_CNT_W-1:0]  cnt;
  logic [REM_W-1:0]               rem;
  logic [ttb_pkg::DIV_STEPS-1:0]  low;
  logic [ttb_pkg::DIV_STEPS-1:0]  quo;
  logic [ttb_pkg::DET_W-1:0]      dmag;
  logic                           neg;
  logic                           ovf;
  logic                           zero;

  logic [ttb_pkg::ACC_W-1:0]      n_abs;
  logic [ttb_pkg::DET_W-1:0]      d_abs;
  logic [REM_W:0]                 trial;
  logic                           fits;
  logic [ttb_pkg::DIV_STEPS:0]    qinc;
  logic [ttb_pkg::DIV_STEPS-1:0]  qh;

  assign n_abs = num[ttb_pkg::ACC_W-1] ? ttb_pkg::ACC_W'(-num) : num;
  assign d_abs = den[ttb_pkg::DET_W-1] ? ttb_pkg::DET_W'(-den) : den;
  assign trial = {rem, low[ttb_pkg::DIV_STEPS-1]};
  assign fits  = trial >= {2'b00, dmag};
  assign qinc  = {1'b0, quo} + (ttb_pkg::DIV_STEPS+1)'(1);
  assign qh    = qinc[ttb_pkg::DIV_STEPS:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DV_IDLE;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            neg  <= num[ttb_pkg::ACC_W-1] ^ den[ttb_pkg::DET_W-1];
            dmag <= d_abs;
            zero <= (n_abs == '0);
            ovf  <= ({(ttb_pkg::DET_W-NHI_W)'(0), n_abs[ttb_pkg::ACC_W-1:NLO_W]} >= d_abs);
            rem  <= REM_W'(n_abs[ttb_pkg::ACC_W-1:NLO_W]);
            low  <= {n_abs[NLO_W-1:0], (ttb_pkg::DIV_STEPS-NLO_W)'(0)};
            quo  <= '0;
            cnt  <= ttb_pkg::DIV_CNT_W'(ttb_pkg::DIV_STEPS);
            // A zero numerator or a quotient past the range needs no iterations.
            if (n_abs == '0 ||
                {(ttb_pkg::DET_W-NHI_W)'(0), n_abs[ttb_pkg::ACC_W-1:NLO_W]} >= d_abs) begin
              state <= DV_FIN;
            end else begin
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          if (fits) begin
            rem <= REM_W'(trial - {2'b00, dmag});
          end else begin
            rem <= trial[REM_W-1:0];
          end
          quo <= {quo[ttb_pkg::DIV_STEPS-2:0], fits};
          low <= {low[ttb_pkg::DIV_STEPS-2:0], 1'b0};
          cnt <= cnt - ttb_pkg::DIV_CNT_W'(1);
          if (cnt == ttb_pkg::DIV_CNT_W'(1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          stat.done <= 1'b1;
          state     <= DV_IDLE;
          if (zero) begin
            quot     <= '0;
            stat.sat <= 1'b0;
          end else if (neg) begin
            if (ovf || qh > {2'b00, 1'b1, (ttb_pkg::OUT_W-1)'(0)}) begin
              quot     <= {1'b1, (ttb_pkg::OUT_W-1)'(0)};
              stat.sat <= 1'b1;
            end else begin
              quot     <= -qh[ttb_pkg::OUT_W-1:0];
              stat.sat <= 1'b0;
            end
          end else begin
            if (ovf || qh > {3'b000, {(ttb_pkg::OUT_W-1){1'b1}}}) begin
              quot     <= {1'b0, {(ttb_pkg::OUT_W-1){1'b1}}};
              stat.sat <= 1'b1;
            end else begin
              quot     <= qh[ttb_pkg::OUT_W-1:0];
              stat.sat <= 1'b0;
            end
          end
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/triangle_tangent_bitangent_core.sv */
// Top level: vertex store, operation sequencer, shared multiplier and divider.
//
//  channel | dir | handshake     | word
//  vtx     | in  | valid/ready   | pos_x, pos_y, pos_z, tex_u, tex_v
//  res     | out | valid/ready   | tangent_xyz, bitangent_xyz, degenerate, saturated
//
// The first two vertices of a triangle are only held in the vertex store.
// The third vertex starts 14 multiplies on one multiplier, in pairs, and 6 divides
// on one bit-serial divider; a zero determinant skips the other multiplies and all
// divides. vtx.ready is low while that runs.
// A result waits in the output register while the next triangle is loaded.
// Reset is synchronous; it clears the vertex count and all handshake state.
module triangle_tangent_bitangent_core (
  input  logic         clk,
  input  logic         rst,
  ttb_vtx_if.sink      vtx,
  ttb_res_if.source    res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  localparam int POS_IDX_W = 2;

  state_t state;
  logic [1:0] count;
  logic [1:0] phase;
  logic [2:0] term;

  logic signed [ttb_pkg::POS_W-1:0] held_pos [2][3];
  logic signed [ttb_pkg::TEX_W-1:0] held_tex [2][2];

  logic signed [ttb_pkg::DPOS_W-1:0] dp1 [3];
  logic signed [ttb_pkg::DPOS_W-1:0] dp2 [3];
  logic signed [ttb_pkg::DTEX_W-1:0] du1, dv1, du2, dv2;
  logic signed [ttb_pkg::DET_W-1:0]  det;

  logic signed [ttb_pkg::OUT_W-1:0]  comp [ttb_pkg::NUM_COMP];
  logic                              degen;
  logic                              sat_any;

  ttb_pkg::ttb_mac_ctl_t              mac_ctl;
  logic signed [ttb_pkg::DPOS_W-1:0]  mac_a;
  logic signed [ttb_pkg::DTEX_W-1:0]  mac_b;
  logic signed [ttb_pkg::ACC_W-1:0]   acc;
  logic                               div_start;
  ttb_pkg::ttb_div_stat_t             div_stat;
  logic signed [ttb_pkg::OUT_W-1:0]   quot;

  logic [POS_IDX_W-1:0] ci;

  logic vtx_take;

  assign vtx.ready = (state == ST_IDLE);
  assign vtx_take  = vtx.valid && vtx.ready;

  // Term 0 is the determinant, terms 1-3 tangent x/y/z, terms 4-6 bitangent x/y/z.
  assign ci = (term >= 3'd4) ? POS_IDX_W'(term - 3'd4) : POS_IDX_W'(term - 3'd1);

  always_comb begin
    mac_a = ttb_pkg::DPOS_W'(du1);
    mac_b = dv2;
    if (term == 3'd0) begin
      if (phase == 2'd0) begin
        mac_a = ttb_pkg::DPOS_W'(du1);
        mac_b = dv2;
      end else begin
        mac_a = ttb_pkg::DPOS_W'(dv1);
        mac_b = du2;
      end
    end else if (term <= 3'd3) begin
      if (phase == 2'd0) begin
        mac_a = dp1[ci];
        mac_b = dv2;
      end else begin
        mac_a = dp2[ci];
        mac_b = dv1;
      end
    end else begin
      if (phase == 2'd0) begin
        mac_a = dp2[ci];
        mac_b = du1;
      end else begin
        mac_a = dp1[ci];
        mac_b = du2;
      end
    end
  end

  assign mac_ctl.valid = (state == ST_MUL) && (phase <= 2'd1);
  assign mac_ctl.first = (phase == 2'd0);
  assign div_start     = (state == ST_MUL) && (phase == 2'd3) && (term != 3'd0);

  ttb_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  ttb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (det),
    .stat  (div_stat),
    .quot  (quot)
  );

  // Vertex store and deltas.
  always_ff @(posedge clk) begin
    if (vtx_take) begin
      if (count != 2'd2) begin
        held_pos[count[0]][0] <= vtx.pos_x;
        held_pos[count[0]][1] <= vtx.pos_y;
        held_pos[count[0]][2] <= vtx.pos_z;
        held_tex[count[0]][0] <= vtx.tex_u;
        held_tex[count[0]][1] <= vtx.tex_v;
      end else begin
        dp1[0] <= ttb_pkg::DPOS_W'(held_pos[1][0]) - ttb_pkg::DPOS_W'(held_pos[0][0]);
        dp1[1] <= ttb_pkg::DPOS_W'(held_pos[1][1]) - ttb_pkg::DPOS_W'(held_pos[0][1]);
        dp1[2] <= ttb_pkg::DPOS_W'(held_pos[1][2]) - ttb_pkg::DPOS_W'(held_pos[0][2]);
        dp2[0] <= ttb_pkg::DPOS_W'(vtx.pos_x) - ttb_pkg::DPOS_W'(held_pos[0][0]);
        dp2[1] <= ttb_pkg::DPOS_W'(vtx.pos_y) - ttb_pkg::DPOS_W'(held_pos[0][1]);
        dp2[2] <= ttb_pkg::DPOS_W'(vtx.pos_z) - ttb_pkg::DPOS_W'(held_pos[0][2]);
        du1 <= ttb_pkg::DTEX_W'(held_tex[1][0]) - ttb_pkg::DTEX_W'(held_tex[0][0]);
        dv1 <= ttb_pkg::DTEX_W'(held_tex[1][1]) - ttb_pkg::DTEX_W'(held_tex[0][1]);
        du2 <= ttb_pkg::DTEX_W'(vtx.tex_u) - ttb_pkg::DTEX_W'(held_tex[0][0]);
        dv2 <= ttb_pkg::DTEX_W'(vtx.tex_v) - ttb_pkg::DTEX_W'(held_tex[0][1]);
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= 2'd0;
      phase     <= 2'd0;
      term      <= 3'd0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != ST_OUT) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (vtx_take) begin
            if (count == 2'd2) begin
              count   <= 2'd0;
              phase   <= 2'd0;
              term    <= 3'd0;
              degen   <= 1'b0;
              sat_any <= 1'b0;
              state   <= ST_MUL;
            end else begin
              count <= count + 2'd1;
            end
          end
        end
        ST_MUL: begin
          // Phase wraps from 3 back to 0 at the end of each pair.
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            if (term == 3'd0) begin
              det   <= ttb_pkg::DET_W'(acc);
              term  <= 3'd1;
              if (acc == '0) begin
                degen <= 1'b1;
                for (int i = 0; i < ttb_pkg::NUM_COMP; i++) begin
                  comp[i] <= '0;
                end
                state <= ST_OUT;
              end
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            comp[term - 3'd1] <= quot;
            sat_any <= sat_any | div_stat.sat;
            phase   <= 2'd0;
            if (term == 3'(ttb_pkg::NUM_COMP)) begin
              state <= ST_OUT;
            end else begin
              term  <= term + 3'd1;
              state <= ST_MUL;
            end
          end
        end
        ST_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.tangent_x   <= comp[0];
            res.tangent_y   <= comp[1];
            res.tangent_z   <= comp[2];
            res.bitangent_x <= comp[3];
            res.bitangent_y <= comp[4];
            res.bitangent_z <= comp[5];
            res.degenerate  <= degen;
            res.saturated   <= sat_any;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |-> res.tangent_x == 0 && res.tangent_y == 0 &&
      res.tangent_z == 0 && res.bitangent_x == 0 && res.bitangent_y == 0 &&
      res.bitangent_z == 0 && !res.saturated)
    else $error("degenerate result with nonzero vector or saturation");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("vertex count out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_DIV) |-> !vtx.ready)
    else $error("vertex accepted while a triangle is in progress");

endmodule
